### hdl/gcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared types and constants of the Gaussian clutter modulator.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int unsigned MaxFrameDef = 1024;

  localparam int unsigned InW     = 16;
  localparam int unsigned OutW    = 32;
  localparam int unsigned ClutW   = 24;
  localparam int unsigned SigmaW  = 24;
  localparam int unsigned SeedW   = 32;
  localparam int unsigned FlenW   = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  localparam logic [SigmaW-1:0] SigmaRst = 24'd10486;
  localparam logic [SeedW-1:0]  SeedRst  = 32'd5489;
  localparam logic [FlenW-1:0]  FlenRst  = 11'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSigma       = 2'd0,
    CfgSeed        = 2'd1,
    CfgFrameLength = 2'd2
  } cfg_idx_e;

  // Mersenne twister
  localparam int unsigned TwN      = 624;
  localparam int unsigned TwM      = 397;
  localparam logic [31:0] TwInit   = 32'd1812433253;
  localparam logic [31:0] TwMag    = 32'h9908B0DF;
  localparam logic [31:0] TwTmpB   = 32'h9D2C5680;
  localparam logic [31:0] TwTmpC   = 32'hEFC60000;

  // Fixed point constants (Q2.30)
  localparam logic [31:0] OneQ30    = 32'd1073741824;
  localparam logic [31:0] PiQ30     = 32'd3373259426;
  localparam logic [31:0] TwoLn2Q30 = 32'd1488522236;

  localparam logic [22:0] MagMax = 23'h7FFFFF;

  // Reciprocals for the constant divides of the trig series
  localparam logic [31:0] Rcp42 = 32'((64'd1 << 32) / 42);
  localparam logic [31:0] Rcp20 = 32'((64'd1 << 32) / 20);
  localparam logic [31:0] Rcp6  = 32'((64'd1 << 32) / 6);
  localparam logic [31:0] Rcp56 = 32'((64'd1 << 32) / 56);
  localparam logic [31:0] Rcp30 = 32'((64'd1 << 32) / 30);
  localparam logic [31:0] Rcp12 = 32'((64'd1 << 32) / 12);
  localparam logic [31:0] Rcp2  = 32'((64'd1 << 32) / 2);

  typedef struct packed {
    logic signed [ClutW-1:0] re;
    logic signed [ClutW-1:0] im;
  } clutter_t;

  typedef struct packed {
    logic idle;
    logic done;
  } bld_stat_t;

  // Series step: sine terms 0..2, cosine terms 3..6
  function automatic logic [5:0] div_sel(input logic [2:0] j);
    logic [5:0] d;
    case (j)
      3'd0:    d = 6'd42;
      3'd1:    d = 6'd20;
      3'd2:    d = 6'd6;
      3'd3:    d = 6'd56;
      3'd4:    d = 6'd30;
      3'd5:    d = 6'd12;
      default: d = 6'd2;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] rcp_sel(input logic [2:0] j);
    logic [31:0] r;
    case (j)
      3'd0:    r = Rcp42;
      3'd1:    r = Rcp20;
      3'd2:    r = Rcp6;
      3'd3:    r = Rcp56;
      3'd4:    r = Rcp30;
      3'd5:    r = Rcp12;
      default: r = Rcp2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/gcm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcm_if
// Valid/ready stream interfaces for sample input and modulated output.
// ----------------------------------------------------------------------------
interface gcm_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [gcm_pkg::InW-1:0]    in_re;
  logic signed [gcm_pkg::InW-1:0]    in_im;

  modport source (output valid, output in_re, output in_im, input ready);
  modport sink   (input valid, input in_re, input in_im, output ready);
endinterface

interface gcm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gcm_pkg::OutW-1:0]   out_re;
  logic signed [gcm_pkg::OutW-1:0]   out_im;
  logic signed [gcm_pkg::ClutW-1:0]  clutter_re;
  logic signed [gcm_pkg::ClutW-1:0]  clutter_im;
  logic                              frame_last;

  modport source (output valid, output out_re, output out_im, output clutter_re,
                  output clutter_im, output frame_last, input ready);
  modport sink   (input valid, input out_re, input out_im, input clutter_re,
                  input clutter_im, input frame_last, output ready);
endinterface
`default_nettype wire

### hdl/gcm_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcm_builder
// Twister state memory, seeding pass and sequential clutter table builder.
// ----------------------------------------------------------------------------
module gcm_builder #(
  parameter int unsigned MaxFrame = gcm_pkg::MaxFrameDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [gcm_pkg::SigmaW-1:0]    sigma_i,
  input  wire logic [gcm_pkg::SeedW-1:0]     seed_i,
  input  wire logic                          reseed_i,
  input  wire logic                          start_i,
  input  wire logic [$clog2(MaxFrame+1)-1:0] len_i,
  output gcm_pkg::bld_stat_t                 stat_o,
  output logic                               tbl_we_o,
  output logic [$clog2(MaxFrame)-1:0]        tbl_addr_o,
  output gcm_pkg::clutter_t                  tbl_data_o
);

  localparam int unsigned IdxW = $clog2(MaxFrame);
  localparam int unsigned LenW = $clog2(MaxFrame + 1);
  localparam int unsigned TwAw = $clog2(gcm_pkg::TwN);

  typedef enum logic [4:0] {
    S_IDLE, S_SEED, S_TW_RD, S_TW_WR, S_NORM, S_SQ_MUL, S_SQ_UPD,
    S_LN_MUL, S_LN_UPD, S_SQRT, S_AMP_MUL, S_AMP_UPD, S_TH_MUL, S_TH_UPD,
    S_X2_MUL, S_X2_UPD, S_DIV_MUL, S_DIV_FIX, S_TRM_MUL, S_TRM_UPD,
    S_SIN_MUL, S_SIN_UPD, S_RE_MUL, S_RE_UPD, S_IM_MUL, S_IM_UPD
  } state_e;

  state_e            state_q;
  logic [TwAw-1:0]   si_q, tp_q;
  logic              second_q;
  logic [31:0]       cur_q, w1_q, w2_q;
  logic [32:0]       m_q;
  logic [5:0]        p_q;
  logic [23:0]       l_q;
  logic [4:0]        k_q;
  logic [2:0]        j_q;
  logic [47:0]       sv_q;
  logic [25:0]       rem_q;
  logic [23:0]       root_q;
  logic [27:0]       amp_q;
  logic [29:0]       th_q, x2_q;
  logic [30:0]       a_q, t_q, s_q, c_q;
  logic signed [23:0] re_q;
  logic [IdxW-1:0]   idx_q;
  logic [LenW-1:0]   len_q;
  logic [63:0]       prod_q;

  // twister memory, two registered read ports
  logic [31:0]       tw_mem_q [gcm_pkg::TwN];
  logic [31:0]       rd_a_q, rd_b_q;
  logic [TwAw-1:0]   ra, rb, tw_wa;
  logic              tw_we;
  logic [31:0]       tw_wd;

  logic [31:0] seed_mix, seed_val;
  logic [31:0] tv, ty, ty1, ty2, ty3, ty4;
  logic [32:0] mm;
  logic [29:0] dval;
  logic [27:0] rem_n, trial;
  logic [31:0] mul_a, mul_b;
  logic [1:0]  quad;
  logic [31:0] fval, afv;
  logic        fneg, cneg, sneg, neg_sel;
  logic [30:0] cm, sm;
  logic [31:0] q0, rem_d, qv;
  logic [37:0] q0c;
  logic [5:0]  dv;
  logic [30:0] t_d;
  logic [63:0] rsum;
  logic [22:0] mag;
  logic signed [23:0] scaled;
  logic        last_ent;

  // seeding recurrence
  always_comb begin
    seed_mix = w1_q ^ (w1_q >> 30);
    seed_val = (si_q == '0) ? seed_i : seed_mix * gcm_pkg::TwInit + 32'(si_q);
  end

  // lazy twist of one word and tempering
  always_comb begin
    ra  = (tp_q == TwAw'(gcm_pkg::TwN - 1)) ? '0 : tp_q + 1'b1;
    rb  = (tp_q >= TwAw'(gcm_pkg::TwN - gcm_pkg::TwM))
        ? tp_q - TwAw'(gcm_pkg::TwN - gcm_pkg::TwM)
        : tp_q + TwAw'(gcm_pkg::TwM);
    tv  = {cur_q[31], rd_a_q[30:0]};
    ty  = rd_b_q ^ (tv >> 1) ^ (tv[0] ? gcm_pkg::TwMag : 32'd0);
    ty1 = ty ^ (ty >> 11);
    ty2 = ty1 ^ ((ty1 << 7) & gcm_pkg::TwTmpB);
    ty3 = ty2 ^ ((ty2 << 15) & gcm_pkg::TwTmpC);
    ty4 = ty3 ^ (ty3 >> 18);
  end

  always_comb begin
    tw_we = 1'b0;
    tw_wa = tp_q;
    tw_wd = ty;
    if (state_q == S_SEED) begin
      tw_we = 1'b1;
      tw_wa = si_q;
      tw_wd = seed_val;
    end else if (state_q == S_TW_WR) begin
      tw_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tw_we) begin
      tw_mem_q[tw_wa] <= tw_wd;
    end
    rd_a_q <= tw_mem_q[ra];
    rd_b_q <= tw_mem_q[rb];
  end

  // angle split: quadrant and signed residual
  always_comb begin
    quad = 2'((w2_q + 32'h2000_0000) >> 30);
    fval = w2_q - {quad, 30'd0};
    fneg = fval[31];
    afv  = fneg ? (~fval + 32'd1) : fval;
    case (quad)
      2'd0: begin
        cm = c_q; cneg = 1'b0;  sm = s_q; sneg = fneg;
      end
      2'd1: begin
        cm = s_q; cneg = !fneg; sm = c_q; sneg = 1'b0;
      end
      2'd2: begin
        cm = c_q; cneg = 1'b1;  sm = s_q; sneg = !fneg;
      end
      default: begin
        cm = s_q; cneg = fneg;  sm = c_q; sneg = 1'b1;
      end
    endcase
  end

  always_comb begin
    mm    = prod_q[63:31];
    dval  = 30'(32'd1 << 29) - {p_q, l_q};
    rem_n = {rem_q, sv_q[47:46]};
    trial = {2'b00, root_q, 2'b01};
    dv    = gcm_pkg::div_sel(j_q);
    q0    = prod_q[63:32];
    q0c   = 38'(q0) * 38'(dv);
    rem_d = 32'(a_q) - q0c[31:0];
    qv    = (rem_d >= 32'(dv)) ? q0 + 32'd1 : q0;
    t_d   = 31'(gcm_pkg::OneQ30 - qv);
    rsum  = prod_q + (64'd1 << 34);
    mag   = (rsum[63:35] > 29'(gcm_pkg::MagMax)) ? gcm_pkg::MagMax : rsum[57:35];
    neg_sel = (state_q == S_RE_UPD) ? cneg : sneg;
    scaled  = neg_sel ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    last_ent = (LenW'(idx_q) + 1'b1) == len_q;
  end

  // shared 32x32 multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ_MUL: begin
        mul_a = m_q[31:0]; mul_b = m_q[31:0];
      end
      S_LN_MUL: begin
        mul_a = 32'(dval); mul_b = gcm_pkg::TwoLn2Q30;
      end
      S_AMP_MUL: begin
        mul_a = 32'(sigma_i); mul_b = 32'(root_q);
      end
      S_TH_MUL: begin
        mul_a = afv; mul_b = gcm_pkg::PiQ30;
      end
      S_X2_MUL: begin
        mul_a = 32'(th_q); mul_b = 32'(th_q);
      end
      S_DIV_MUL: begin
        mul_a = 32'(a_q); mul_b = gcm_pkg::rcp_sel(j_q);
      end
      S_TRM_MUL: begin
        mul_a = 32'(x2_q); mul_b = 32'(t_q);
      end
      S_SIN_MUL: begin
        mul_a = 32'(th_q); mul_b = 32'(t_q);
      end
      S_RE_MUL: begin
        mul_a = 32'(amp_q); mul_b = 32'(cm);
      end
      S_IM_MUL: begin
        mul_a = 32'(amp_q); mul_b = 32'(sm);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_SEED;
      si_q     <= '0;
      tp_q     <= '0;
      second_q <= 1'b0;
      k_q      <= '0;
      j_q      <= '0;
      idx_q    <= '0;
      len_q    <= '0;
    end else if (reseed_i) begin
      state_q <= S_SEED;
      si_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            len_q    <= len_i;
            idx_q    <= '0;
            second_q <= 1'b0;
            state_q  <= S_TW_RD;
          end
        end
        S_SEED: begin
          w1_q <= seed_val;
          if (si_q == '0) begin
            cur_q <= seed_val;
          end
          if (si_q == TwAw'(gcm_pkg::TwN - 1)) begin
            tp_q    <= '0;
            state_q <= S_IDLE;
          end else begin
            si_q <= si_q + 1'b1;
          end
        end
        S_TW_RD: begin
          state_q <= S_TW_WR;
        end
        S_TW_WR: begin
          cur_q <= rd_a_q;
          tp_q  <= ra;
          if (!second_q) begin
            w1_q     <= ty4;
            second_q <= 1'b1;
            state_q  <= S_TW_RD;
          end else begin
            w2_q     <= ty4;
            second_q <= 1'b0;
            m_q      <= {1'b0, w1_q} + 33'd1;
            p_q      <= 6'd32;
            state_q  <= S_NORM;
          end
        end
        S_NORM: begin
          if (m_q[32]) begin
            m_q     <= m_q >> 1;
            k_q     <= '0;
            l_q     <= '0;
            state_q <= S_SQ_MUL;
          end else begin
            m_q <= m_q << 1;
            p_q <= p_q - 1'b1;
          end
        end
        S_SQ_MUL: begin
          state_q <= S_SQ_UPD;
        end
        S_SQ_UPD: begin
          if (mm[32]) begin
            l_q <= {l_q[22:0], 1'b1};
            m_q <= mm >> 1;
          end else begin
            l_q <= {l_q[22:0], 1'b0};
            m_q <= mm;
          end
          if (k_q == 5'd23) begin
            state_q <= S_LN_MUL;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_SQ_MUL;
          end
        end
        S_LN_MUL: begin
          state_q <= S_LN_UPD;
        end
        S_LN_UPD: begin
          sv_q    <= {prod_q[61:30], 16'd0};
          rem_q   <= '0;
          root_q  <= '0;
          k_q     <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          sv_q <= sv_q << 2;
          if (rem_n >= trial) begin
            rem_q  <= 26'(rem_n - trial);
            root_q <= {root_q[22:0], 1'b1};
          end else begin
            rem_q  <= 26'(rem_n);
            root_q <= {root_q[22:0], 1'b0};
          end
          if (k_q == 5'd23) begin
            state_q <= S_AMP_MUL;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_AMP_MUL: begin
          state_q <= S_AMP_UPD;
        end
        S_AMP_UPD: begin
          amp_q   <= prod_q[47:20];
          state_q <= S_TH_MUL;
        end
        S_TH_MUL: begin
          state_q <= S_TH_UPD;
        end
        S_TH_UPD: begin
          th_q    <= prod_q[60:31];
          state_q <= S_X2_MUL;
        end
        S_X2_MUL: begin
          state_q <= S_X2_UPD;
        end
        S_X2_UPD: begin
          x2_q    <= prod_q[59:30];
          a_q     <= {1'b0, prod_q[59:30]};
          j_q     <= '0;
          state_q <= S_DIV_MUL;
        end
        S_DIV_MUL: begin
          state_q <= S_DIV_FIX;
        end
        S_DIV_FIX: begin
          t_q <= t_d;
          if (j_q == 3'd2) begin
            state_q <= S_SIN_MUL;
          end else if (j_q == 3'd6) begin
            c_q     <= t_d;
            state_q <= S_RE_MUL;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_TRM_MUL;
          end
        end
        S_TRM_MUL: begin
          state_q <= S_TRM_UPD;
        end
        S_TRM_UPD: begin
          a_q     <= prod_q[60:30];
          state_q <= S_DIV_MUL;
        end
        S_SIN_MUL: begin
          state_q <= S_SIN_UPD;
        end
        S_SIN_UPD: begin
          s_q     <= prod_q[60:30];
          a_q     <= {1'b0, x2_q};
          j_q     <= 3'd3;
          state_q <= S_DIV_MUL;
        end
        S_RE_MUL: begin
          state_q <= S_RE_UPD;
        end
        S_RE_UPD: begin
          re_q    <= scaled;
          state_q <= S_IM_MUL;
        end
        S_IM_MUL: begin
          state_q <= S_IM_UPD;
        end
        S_IM_UPD: begin
          if (last_ent) begin
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_TW_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign stat_o.idle     = (state_q == S_IDLE);
  assign stat_o.done     = (state_q == S_IM_UPD) && last_ent;
  assign tbl_we_o        = (state_q == S_IM_UPD);
  assign tbl_addr_o      = idx_q;
  assign tbl_data_o.re   = re_q;
  assign tbl_data_o.im   = scaled;

endmodule
`default_nettype wire

### hdl/gaussian_clutter_modulator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_clutter_modulator_core
// Radar clutter modulator: input samples times a stored Box-Muller clutter table.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    in_re, in_im (Q1.15)
//  out_o     out  valid/ready    out_re, out_im (Q16.15), clutter_re/im (Q8.15),
//                                frame_last
//  cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (sigma, seed, frame_length)
//
//  Streaming: one word per cycle while the output is ready and the builder idle;
//  the stages are table RAM read, complex products, round and output register.
//  After reset and after every seed write the twister memory is seeded, one
//  word a cycle; no input word is taken meanwhile.
//  A frame whose table must be rebuilt waits at its first word while the
//  sequential builder makes each entry in turn (two twister draws, log by
//  squaring, bit-serial sqrt, trig series on one multiplier). Output stalls
//  back up stage by stage; the front stalls when full or the builder is busy.
// ----------------------------------------------------------------------------
module gaussian_clutter_modulator_core #(
  parameter int unsigned MaxFrame = gcm_pkg::MaxFrameDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  gcm_in_if.sink                             in_i,
  gcm_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [gcm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [gcm_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MaxFrame);
  localparam int unsigned LenW = $clog2(MaxFrame + 1);

  // config registers
  logic [gcm_pkg::SigmaW-1:0] sigma_q;
  logic [gcm_pkg::SeedW-1:0]  seed_q;
  logic [gcm_pkg::FlenW-1:0]  flen_q;

  // frame state
  logic [IdxW-1:0] pos_q;
  logic            tready_q;
  logic [LenW-1:0] tlen_q;
  logic [LenW-1:0] eff;
  logic            need, at_start, last_d;

  logic reseed, start, accept;
  logic en1, en2, en3;

  gcm_pkg::bld_stat_t bstat;
  logic               tbl_we;
  logic [IdxW-1:0]    tbl_addr;
  gcm_pkg::clutter_t  tbl_wd;

  // clutter table RAM
  gcm_pkg::clutter_t tbl_mem_q [MaxFrame];

  // stage 1: table read, input capture
  logic                            v1_q, last1_q;
  logic signed [gcm_pkg::InW-1:0]  xr1_q, xi1_q;
  gcm_pkg::clutter_t               c1_q;
  // stage 2: partial products
  logic                            v2_q, last2_q;
  logic signed [39:0]              prr_q, pii_q, pri_q, pir_q;
  gcm_pkg::clutter_t               c2_q;
  // stage 3: output register
  logic                            ov_q, olast_q;
  logic signed [gcm_pkg::OutW-1:0] ore_q, oim_q;
  gcm_pkg::clutter_t               oc_q;

  logic signed [41:0] sum_re, sum_im;

  // effective length: zero acts as one, clamp to table depth
  always_comb begin
    if (flen_q == '0) begin
      eff = LenW'(1);
    end else if (32'(flen_q) > 32'(MaxFrame)) begin
      eff = LenW'(MaxFrame);
    end else begin
      eff = LenW'(flen_q);
    end
    need     = !tready_q || (tlen_q != eff);
    at_start = (pos_q == '0);
    last_d   = (32'(pos_q) + 32'd1) >= 32'(tlen_q);
  end

  assign reseed = cfg_we_i && (cfg_idx_i == gcm_pkg::CfgSeed);

  // elastic pipeline enables
  assign en3 = !ov_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1 && bstat.idle && !(at_start && need);
  assign accept     = in_i.valid && in_i.ready;
  // a frame start that needs a new table kicks the builder
  assign start      = in_i.valid && en1 && bstat.idle && at_start && need;

  gcm_builder #(
    .MaxFrame (MaxFrame)
  ) u_bld (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sigma_i    (sigma_q),
    .seed_i     (seed_q),
    .reseed_i   (reseed),
    .start_i    (start),
    .len_i      (eff),
    .stat_o     (bstat),
    .tbl_we_o   (tbl_we),
    .tbl_addr_o (tbl_addr),
    .tbl_data_o (tbl_wd)
  );

  // config and frame control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q  <= gcm_pkg::SigmaRst;
      seed_q   <= gcm_pkg::SeedRst;
      flen_q   <= gcm_pkg::FlenRst;
      pos_q    <= '0;
      tready_q <= 1'b0;
      tlen_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gcm_pkg::CfgSigma:       sigma_q <= cfg_data_i[gcm_pkg::SigmaW-1:0];
          gcm_pkg::CfgSeed:        seed_q  <= cfg_data_i[gcm_pkg::SeedW-1:0];
          gcm_pkg::CfgFrameLength: flen_q  <= cfg_data_i[gcm_pkg::FlenW-1:0];
          default:                 sigma_q <= sigma_q;
        endcase
      end
      // seed write forces a rebuild and wins over a finishing build
      if (reseed) begin
        tready_q <= 1'b0;
      end else if (bstat.done) begin
        tready_q <= 1'b1;
      end else if (start) begin
        tready_q <= 1'b0;
      end
      if (start) begin
        tlen_q <= eff;
      end
      if (accept) begin
        pos_q <= last_d ? '0 : pos_q + 1'b1;
      end
    end
  end

  // table RAM: builder writes, stream reads
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem_q[tbl_addr] <= tbl_wd;
    end
    if (accept) begin
      c1_q    <= tbl_mem_q[pos_q];
      xr1_q   <= in_i.in_re;
      xi1_q   <= in_i.in_im;
      last1_q <= last_d;
    end
  end

  // products
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      prr_q   <= 40'(xr1_q) * 40'(c1_q.re);
      pii_q   <= 40'(xi1_q) * 40'(c1_q.im);
      pri_q   <= 40'(xr1_q) * 40'(c1_q.im);
      pir_q   <= 40'(xi1_q) * 40'(c1_q.re);
      c2_q    <= c1_q;
      last2_q <= last1_q;
    end
  end

  // round half up at Q15; the sum always fits 32 bits after the shift
  always_comb begin
    sum_re = 42'(prr_q) - 42'(pii_q) + 42'sd16384;
    sum_im = 42'(pri_q) + 42'(pir_q) + 42'sd16384;
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      ore_q   <= 32'(sum_re >>> 15);
      oim_q   <= 32'(sum_im >>> 15);
      oc_q    <= c2_q;
      olast_q <= last2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        ov_q <= v2_q;
      end
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_re     = ore_q;
  assign out_o.out_im     = oim_q;
  assign out_o.clutter_re = oc_q.re;
  assign out_o.clutter_im = oc_q.im;
  assign out_o.frame_last = olast_q;

endmodule
`default_nettype wire

### tb/gcm_checker.sv
// ----------------------------------------------------------------------------
// gcm_checker
// Watches the config port and both streams, models the clutter table and
// the modulation, and compares every output word with the oldest prediction.
// ----------------------------------------------------------------------------
module gcm_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  gcm_in_if                                in_mon,
  gcm_out_if                               out_mon,
  input  wire logic                        cfg_we_i,
  input  wire logic [gcm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [gcm_pkg::CfgW-1:0]    cfg_data_i,
  output int unsigned                      fail_cnt_o,
  output int unsigned                      words_due_o,
  output int unsigned                      tables_built_o
);
  import gcm_pkg::*;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic signed [OutW-1:0]  re;
    logic signed [OutW-1:0]  im;
    logic signed [ClutW-1:0] cre;
    logic signed [ClutW-1:0] cim;
    logic                    last;
  } mod_word_t;

  // model state
  logic [SigmaW-1:0]       sigma;
  logic [FlenW-1:0]        flen;
  logic [31:0]             mt [TwN];
  int unsigned             mt_pos;
  logic signed [ClutW-1:0] tab_re [MaxFrameDef];
  logic signed [ClutW-1:0] tab_im [MaxFrameDef];
  int unsigned             samp_pos;
  logic                    tab_ok;
  int unsigned             tab_len;

  mod_word_t               due_q [$];

  function automatic void twister_seed(input logic [31:0] s);
    logic [31:0] p;
    mt[0] = s;
    for (int i = 1; i < TwN; i++) begin
      p = mt[i-1];
      mt[i] = TwInit * (p ^ (p >> 30)) + 32'(i);
    end
    mt_pos = TwN;
  endfunction

  function automatic logic [31:0] twister_draw();
    logic [31:0] v;
    logic [31:0] y;
    if (mt_pos >= TwN) begin
      for (int i = 0; i < TwN; i++) begin
        v = (mt[i] & 32'h8000_0000) | (mt[(i+1) % TwN] & 32'h7FFF_FFFF);
        mt[i] = mt[(i+TwM) % TwN] ^ (v >> 1) ^ (v[0] ? TwMag : 32'd0);
      end
      mt_pos = 0;
    end
    y = mt[mt_pos];
    mt_pos++;
    y ^= y >> 11;
    y ^= (y << 7) & TwTmpB;
    y ^= (y << 15) & TwTmpC;
    y ^= y >> 18;
    return y;
  endfunction

  function automatic u64_t int_sqrt(input u64_t val);
    u64_t v;
    u64_t res;
    u64_t b;
    v = val;
    res = 0;
    b = u64_t'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // sqrt(-2 ln((w+1)/2^32)) in Q4.20
  function automatic u64_t rayleigh_radius(input logic [31:0] w);
    u64_t x;
    u64_t m;
    u64_t lg;
    u64_t d;
    u64_t t;
    int unsigned p;
    x = u64_t'(w) + 1;
    p = 0;
    while (p < 32 && (x >> (p + 1)) != 0) p++;
    m = (p == 32) ? (x >> 1) : (x << (31 - p));
    lg = 0;
    for (int k = 0; k < 24; k++) begin
      m = (m * m) >> 31;
      lg <<= 1;
      if (m >= (u64_t'(1) << 32)) begin
        lg |= 1;
        m >>= 1;
      end
    end
    lg |= u64_t'(p) << 24;
    d = (u64_t'(32) << 24) - lg;
    t = (d * u64_t'(TwoLn2Q30)) >> 30;
    return int_sqrt(t << 16);
  endfunction

  function automatic u64_t sine_q30(input u64_t x);
    u64_t x2;
    u64_t t;
    x2 = (x * x) >> 30;
    t = u64_t'(OneQ30) - x2 / 42;
    t = u64_t'(OneQ30) - ((x2 * t) >> 30) / 20;
    t = u64_t'(OneQ30) - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic u64_t cosine_q30(input u64_t x);
    u64_t x2;
    u64_t t;
    x2 = (x * x) >> 30;
    t = u64_t'(OneQ30) - x2 / 56;
    t = u64_t'(OneQ30) - ((x2 * t) >> 30) / 30;
    t = u64_t'(OneQ30) - ((x2 * t) >> 30) / 12;
    return u64_t'(OneQ30) - ((x2 * t) >> 30) / 2;
  endfunction

  function automatic logic signed [ClutW-1:0] scale_part(input u64_t amp, input u64_t trig,
                                                         input logic neg);
    u64_t mag;
    mag = (amp * trig + (u64_t'(1) << 34)) >> 35;
    if (mag > u64_t'(MagMax)) mag = u64_t'(MagMax);
    return neg ? -ClutW'(mag) : ClutW'(mag);
  endfunction

  function automatic void fill_clutter_table(input int unsigned len);
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] qsum;
    logic [1:0]  q;
    logic [31:0] fr;
    logic [31:0] afr;
    logic        fneg;
    u64_t        amp;
    u64_t        af;
    u64_t        th;
    u64_t        s;
    u64_t        c;
    for (int i = 0; i < len; i++) begin
      w1   = twister_draw();
      w2   = twister_draw();
      amp  = (u64_t'(sigma) * rayleigh_radius(w1)) >> 20;
      qsum = w2 + 32'h2000_0000;
      q    = qsum[31:30];
      fr   = w2 - {q, 30'd0};
      fneg = fr[31];
      // magnitude taken at 32 bits before widening
      afr  = fneg ? (~fr + 32'd1) : fr;
      af   = u64_t'(afr);
      th   = (af * u64_t'(PiQ30)) >> 31;
      s    = sine_q30(th);
      c    = cosine_q30(th);
      // rotate by quadrant: cos/sin swap roles and signs
      case (q)
        2'd0: begin
          tab_re[i] = scale_part(amp, c, 1'b0);
          tab_im[i] = scale_part(amp, s, fneg);
        end
        2'd1: begin
          tab_re[i] = scale_part(amp, s, !fneg);
          tab_im[i] = scale_part(amp, c, 1'b0);
        end
        2'd2: begin
          tab_re[i] = scale_part(amp, c, 1'b1);
          tab_im[i] = scale_part(amp, s, !fneg);
        end
        default: begin
          tab_re[i] = scale_part(amp, s, fneg);
          tab_im[i] = scale_part(amp, c, 1'b1);
        end
      endcase
    end
    tab_len = len;
    tab_ok  = 1'b1;
    tables_built_o++;
  endfunction

  function automatic logic signed [OutW-1:0] round_sat_q15(input longint v);
    longint r;
    r = (v + (longint'(1) << 14)) >>> 15;
    if (r > longint'(32'sh7FFF_FFFF)) r = longint'(32'sh7FFF_FFFF);
    if (r < -longint'(64'h8000_0000)) r = -longint'(64'h8000_0000);
    return OutW'(r);
  endfunction

  function automatic void predict_word(input logic signed [InW-1:0] xr,
                                       input logic signed [InW-1:0] xi);
    int unsigned             eff;
    int unsigned             idx;
    logic signed [ClutW-1:0] cr;
    logic signed [ClutW-1:0] ci;
    mod_word_t               w;
    if (samp_pos == 0) begin
      eff = flen;
      if (eff < 1) eff = 1;
      if (eff > MaxFrameDef) eff = MaxFrameDef;
      if (!tab_ok || tab_len != eff) fill_clutter_table(eff);
    end
    idx = samp_pos;
    if (idx >= tab_len || idx >= MaxFrameDef) idx = 0;
    cr = tab_re[idx];
    ci = tab_im[idx];
    w.re   = round_sat_q15(longint'(xr) * longint'(cr) - longint'(xi) * longint'(ci));
    w.im   = round_sat_q15(longint'(xr) * longint'(ci) + longint'(xi) * longint'(cr));
    w.cre  = cr;
    w.cim  = ci;
    w.last = (idx + 1 >= tab_len);
    samp_pos = w.last ? 0 : idx + 1;
    due_q = {due_q, w};
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    fail_cnt_o++;
    if (fail_cnt_o <= 40)
      $display("mismatch %s: got %0d expected %0d", field, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mod_word_t w;
    if (!rst_ni) begin
      sigma    = SigmaRst;
      flen     = FlenRst;
      twister_seed(SeedRst);
      samp_pos = 0;
      tab_ok   = 1'b0;
      tab_len  = 0;
      due_q.delete();
      fail_cnt_o     = 0;
      tables_built_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSigma:       sigma = cfg_data_i[SigmaW-1:0];
          CfgSeed: begin
            twister_seed(cfg_data_i[SeedW-1:0]);
            tab_ok = 1'b0;
          end
          CfgFrameLength: flen = cfg_data_i[FlenW-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_word(in_mon.in_re, in_mon.in_im);
      if (out_mon.valid && out_mon.ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          w = due_q.pop_front();
          if (out_mon.out_re !== w.re) report_mismatch("out_re", out_mon.out_re, w.re);
          if (out_mon.out_im !== w.im) report_mismatch("out_im", out_mon.out_im, w.im);
          if (out_mon.clutter_re !== w.cre)
            report_mismatch("clutter_re", out_mon.clutter_re, w.cre);
          if (out_mon.clutter_im !== w.cim)
            report_mismatch("clutter_im", out_mon.clutter_im, w.cim);
          if (out_mon.frame_last !== w.last)
            report_mismatch("frame_last", out_mon.frame_last, w.last);
        end
      end
    end
    words_due_o = due_q.size();
  end

endmodule

### tb/gaussian_clutter_modulator_core_tb.sv
// ----------------------------------------------------------------------------
// gaussian_clutter_modulator_core_tb
// Drives sample words and register writes into the clutter modulator under
// random gaps and output stalls; the checker predicts and compares each word.
// ----------------------------------------------------------------------------
module gaussian_clutter_modulator_core_tb;
  import gcm_pkg::*;

  localparam int unsigned LimitCycles = 2_000_000;
  localparam int unsigned HoldCycles  = 300;
  // index outside the register map, must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_idx;
  logic [CfgW-1:0]      cfg_data;

  int unsigned          fail_cnt;
  int unsigned          words_due;
  int unsigned          tables_built;
  int unsigned          cycles = 0;
  int unsigned          words_sent = 0;
  int unsigned          phases = 0;

  // burst: no gaps on either side; hold_req: one long output stall
  logic                 burst = 1'b0;
  logic                 hold_req = 1'b0;

  gcm_in_if  in_ch ();
  gcm_out_if out_ch ();

  always #10 clk_i = ~clk_i;

  gaussian_clutter_modulator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  gcm_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_cnt_o     (fail_cnt),
    .words_due_o    (words_due),
    .tables_built_o (tables_built)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, words_due);
      $display("gaussian_clutter_modulator_core test failed");
      $finish;
    end
  end

  // register write, one cycle pulse
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one sample word; valid stays high across back-to-back words
  task automatic send_word(input logic signed [InW-1:0] re, input logic signed [InW-1:0] im);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_re <= re;
    in_ch.in_im <= im;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_random(input int unsigned n);
    for (int i = 0; i < n; i++) send_word(InW'($urandom), InW'($urandom));
  endtask

  // wait until every predicted word has come out; the block is then idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    phases++;
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  initial begin
    logic [CfgW-1:0] sig;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CfgSigma;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.in_re <= '0;
    in_ch.in_im <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // largest sigma, seed zero, short frame: extreme sample values
    write_reg(CfgSigma, 32'h00FF_FFFF);
    write_reg(CfgSeed, 32'd0);
    write_reg(CfgFrameLength, 32'd4);
    send_word(16'sh7FFF, 16'sh7FFF);
    send_word(-16'sh8000, -16'sh8000);
    send_word(16'sh7FFF, -16'sh8000);
    send_word(16'sh0000, 16'shFFFF);
    send_word(16'sh0001, 16'sh0000);
    drain();
    // zero sigma, all-ones seed, length zero acts as one
    write_reg(CfgSigma, 32'd0);
    write_reg(CfgSeed, 32'hFFFF_FFFF);
    write_reg(CfgFrameLength, 32'd0);
    send_word(16'sh7FFF, -16'sh8000);
    send_word(-16'sh8000, 16'sh7FFF);
    drain();
    // same effective length and a sigma write: table kept, sigma waits
    write_reg(CfgFrameLength, 32'd1);
    write_reg(CfgSigma, SigmaRst);
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    send_word(16'sh4000, 16'shC000);
    send_word(16'sh7FFF, 16'sh7FFF);
    drain();
    // default seed, length change mid-frame finishes the old frame first
    write_reg(CfgSeed, SeedRst);
    write_reg(CfgFrameLength, 32'd5);
    send_random(2);
    drain();
    write_reg(CfgFrameLength, 32'd3);
    write_reg(CfgSigma, 32'h0010_0000);
    send_random(6);
    drain();
    // seed write between frames: rebuild at next frame start
    write_reg(CfgSeed, 32'h8000_0001);
    send_random(5);
    drain();

    // --- random phases, small frames ---
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0:       sig = SigmaRst;
        1:       sig = 32'($urandom) & 32'h00FF_FFFF;
        2:       sig = 32'h00FF_FFFF;
        default: sig = $urandom_range(0, 32'h0020_0000);
      endcase
      write_reg(CfgSigma, sig);
      if ($urandom_range(0, 1)) write_reg(CfgSeed, $urandom);
      write_reg(CfgFrameLength, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 24));
      burst = (ph % 3 == 0);
      if (ph == 4) begin
        // long output stall while words keep coming: front must back up
        burst    = 1'b1;
        hold_req = 1'b1;
      end
      send_random(50);
      drain();
    end
    burst = 1'b0;

    // --- longest frame: above range clamps to the table size ---
    write_reg(CfgSigma, SigmaRst);
    write_reg(CfgFrameLength, 32'd2047);
    send_random(15);
    drain();
    write_reg(CfgFrameLength, 32'd1024);
    send_random(10);
    drain();

    repeat (20) @(posedge clk_i);
    $display("%0d sample words in %0d phases, %0d clutter tables built,", words_sent,
             phases, tables_built);
    $display("frame lengths 0..24 and 1024, sigma and seed extremes, one long output stall");
    if (fail_cnt == 0) begin
      $display("gaussian_clutter_modulator_core test passed");
    end else begin
      $display("gaussian_clutter_modulator_core test failed");
    end
    $finish;
  end

endmodule
